FILE: rtl/c3zp_pkg.sv
// shared constants, register codes and types of the 3x3 convolution stream
package c3zp_pkg;

   // defaults for the top-level parameters
   localparam int MAX_LINE_WIDTH_DEF = 1024;
   localparam int COEF_FRAC_BITS_DEF = 8;

   // fixed geometry of the kernel and the data
   localparam int KERNEL_SIZE    = 3;
   localparam int PIXEL_W        = 8;
   localparam int COEF_W         = 16;
   localparam int FRAME_WIDTH_W  = 11;
   localparam int FRAME_HEIGHT_W = 12;
   localparam int KROW_W         = KERNEL_SIZE * COEF_W;

   // product of a signed coefficient and an unsigned pixel, and the 9-term sum
   localparam int PROD_W = COEF_W + PIXEL_W + 1;
   localparam int ACC_W  = PROD_W + 4;

   localparam logic [PIXEL_W-1:0] PIXEL_MAX = '1;

   // register port
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_ADDR_W  = 6;
   localparam int REG_ADDR_LSB = 3;
   localparam int REG_INDEX_W = CSR_ADDR_W - REG_ADDR_LSB;

   typedef enum logic [REG_INDEX_W-1:0] {
      REG_FRAME_WIDTH   = 3'd0,
      REG_FRAME_HEIGHT  = 3'd1,
      REG_KERNEL_TOP    = 3'd2,
      REG_KERNEL_MIDDLE = 3'd3,
      REG_KERNEL_BOTTOM = 3'd4
   } reg_index_type;

   // reset values: 640x480 frame, identity kernel (centre 1.0 in Q8.8)
   localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RST   = 11'd640;
   localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST  = 12'd480;
   localparam logic [KROW_W-1:0]         KERNEL_TOP_RST    = 48'h0000_0000_0000;
   localparam logic [KROW_W-1:0]         KERNEL_MIDDLE_RST = 48'h0000_0100_0000;
   localparam logic [KROW_W-1:0]         KERNEL_BOTTOM_RST = 48'h0000_0000_0000;

   typedef logic [KROW_W-1:0] krow_type;

   // configuration seen by the datapath; row 0 is the top kernel row
   typedef struct packed {
      logic [FRAME_WIDTH_W-1:0]  frame_width;
      logic [FRAME_HEIGHT_W-1:0] frame_height;
      krow_type [KERNEL_SIZE-1:0] kernel_rows;
   } cfg_type;

   // per-transaction control decided from the position counters at accept
   typedef struct packed {
      logic emit;
      logic col_zero;
      logic top_off;
      logic bottom_off;
      logic left_off;
      logic right_off;
      logic end_of_row;
      logic end_of_frame;
   } item_info_type;

endpackage

FILE: rtl/c3zp_if.sv
// valid/ready stream interfaces for pixels in and convolved pixels out
interface c3zp_req_if import c3zp_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] pixel_in;
   logic               flush;

   modport source (output valid, pixel_in, flush, input ready);
   modport sink (input valid, pixel_in, flush, output ready);
endinterface

interface c3zp_rsp_if import c3zp_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] pixel_out;
   logic               end_of_row;
   logic               end_of_frame;

   modport source (output valid, pixel_out, end_of_row, end_of_frame, input ready);
   modport sink (input valid, pixel_out, end_of_row, end_of_frame, output ready);
endinterface

FILE: rtl/c3zp_ram.sv
// generic single-clock ram, one write and one registered read port, read-first
module c3zp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // a read at the written address returns the old contents
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/c3zp_csr.sv
// apb register block: frame size and kernel coefficients
module c3zp_csr import c3zp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   logic [FRAME_WIDTH_W-1:0]  frame_width_ff;
   logic [FRAME_HEIGHT_W-1:0] frame_height_ff;
   krow_type                  kernel_top_ff;
   krow_type                  kernel_middle_ff;
   krow_type                  kernel_bottom_ff;
   logic                      wr_strobe;
   reg_index_type             reg_index;

   assign pready    = 1'b1;
   assign wr_strobe = psel && penable && pwrite;
   assign reg_index = reg_index_type'(paddr[CSR_ADDR_W-1:REG_ADDR_LSB]);

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff   <= FRAME_WIDTH_RST;
         frame_height_ff  <= FRAME_HEIGHT_RST;
         kernel_top_ff    <= KERNEL_TOP_RST;
         kernel_middle_ff <= KERNEL_MIDDLE_RST;
         kernel_bottom_ff <= KERNEL_BOTTOM_RST;
      end else if (wr_strobe) begin
         case (reg_index)
            REG_FRAME_WIDTH:   frame_width_ff   <= pwdata[FRAME_WIDTH_W-1:0];
            REG_FRAME_HEIGHT:  frame_height_ff  <= pwdata[FRAME_HEIGHT_W-1:0];
            REG_KERNEL_TOP:    kernel_top_ff    <= pwdata[KROW_W-1:0];
            REG_KERNEL_MIDDLE: kernel_middle_ff <= pwdata[KROW_W-1:0];
            REG_KERNEL_BOTTOM: kernel_bottom_ff <= pwdata[KROW_W-1:0];
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      case (reg_index)
         REG_FRAME_WIDTH:   prdata = CSR_DATA_W'(frame_width_ff);
         REG_FRAME_HEIGHT:  prdata = CSR_DATA_W'(frame_height_ff);
         REG_KERNEL_TOP:    prdata = CSR_DATA_W'(kernel_top_ff);
         REG_KERNEL_MIDDLE: prdata = CSR_DATA_W'(kernel_middle_ff);
         REG_KERNEL_BOTTOM: prdata = CSR_DATA_W'(kernel_bottom_ff);
         default:           prdata = '0;
      endcase
   end

   assign cfg.frame_width    = frame_width_ff;
   assign cfg.frame_height   = frame_height_ff;
   assign cfg.kernel_rows[0] = kernel_top_ff;
   assign cfg.kernel_rows[1] = kernel_middle_ff;
   assign cfg.kernel_rows[2] = kernel_bottom_ff;

endmodule

FILE: rtl/c3zp_ctrl.sv
// input and output position counters, edge flags and the line ram clearing pass
module c3zp_ctrl import c3zp_pkg::*; #(
   parameter int MAX_LINE_WIDTH = MAX_LINE_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  cfg_type                           cfg,
   input  logic                              accept,
   output item_info_type                     info,
   output logic [$clog2(MAX_LINE_WIDTH)-1:0] rd_col,
   output logic                              clear_busy,
   output logic [$clog2(MAX_LINE_WIDTH)-1:0] clear_addr
);

   localparam int COL_W = $clog2(MAX_LINE_WIDTH);
   localparam int WID_W = $clog2(MAX_LINE_WIDTH + 1);
   localparam int CMP_W = (WID_W > FRAME_WIDTH_W) ? WID_W : FRAME_WIDTH_W;
   localparam logic [CMP_W-1:0] MAX_W     = CMP_W'(MAX_LINE_WIDTH);
   localparam logic [COL_W-1:0] LAST_ADDR = COL_W'(MAX_LINE_WIDTH - 1);

   // saturating input row count: only the first two rows matter
   localparam logic [1:0] ROW_FIRST  = 2'd0;
   localparam logic [1:0] ROW_SECOND = 2'd1;
   localparam logic [1:0] ROW_LATER  = 2'd2;

   logic [COL_W-1:0]          in_col_ff, in_col_in;
   logic [1:0]                in_row_ff, in_row_in;
   logic [COL_W-1:0]          out_col_ff, out_col_in;
   logic [FRAME_HEIGHT_W-1:0] out_row_ff, out_row_in;
   logic                      clear_busy_ff, clear_busy_in;
   logic [COL_W-1:0]          clear_addr_ff, clear_addr_in;

   logic [CMP_W-1:0]          fw_ext, eff_w;
   logic [FRAME_HEIGHT_W-1:0] eff_h;
   logic [CMP_W-1:0]          in_col_inc, out_col_inc;
   logic [FRAME_HEIGHT_W:0]   out_row_inc;
   logic                      in_wrap, emit, eor, last_row, eof;

   // effective frame size
   always_comb begin
      fw_ext = CMP_W'(cfg.frame_width);
      if (fw_ext == '0) begin
         eff_w = CMP_W'(1);
      end else if (fw_ext > MAX_W) begin
         eff_w = MAX_W;
      end else begin
         eff_w = fw_ext;
      end
      eff_h = (cfg.frame_height == '0) ? FRAME_HEIGHT_W'(1) : cfg.frame_height;
   end

   // position compares
   assign in_col_inc  = CMP_W'(in_col_ff) + CMP_W'(1);
   assign out_col_inc = CMP_W'(out_col_ff) + CMP_W'(1);
   assign out_row_inc = {1'b0, out_row_ff} + (FRAME_HEIGHT_W + 1)'(1);
   assign in_wrap     = in_col_inc >= eff_w;
   assign eor         = out_col_inc >= eff_w;
   assign last_row    = out_row_inc >= {1'b0, eff_h};
   assign eof         = eor && last_row;
   assign emit        = (in_row_ff == ROW_LATER) ||
                        ((in_row_ff == ROW_SECOND) && (in_col_ff != '0));

   // counter updates on each accepted transaction
   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (accept) begin
         if (in_wrap) begin
            in_col_in = '0;
            if (in_row_ff != ROW_LATER) begin
               in_row_in = in_row_ff + 2'd1;
            end
         end else begin
            in_col_in = in_col_inc[COL_W-1:0];
         end
         if (emit) begin
            if (eof) begin
               in_col_in  = '0;
               in_row_in  = ROW_FIRST;
               out_col_in = '0;
               out_row_in = '0;
            end else if (eor) begin
               out_col_in = '0;
               out_row_in = out_row_inc[FRAME_HEIGHT_W-1:0];
            end else begin
               out_col_in = out_col_inc[COL_W-1:0];
            end
         end
      end
   end

   // clearing pass over the line ram after reset
   always_comb begin
      clear_busy_in = clear_busy_ff;
      clear_addr_in = clear_addr_ff;
      if (clear_busy_ff) begin
         clear_addr_in = clear_addr_ff + COL_W'(1);
         if (clear_addr_ff == LAST_ADDR) begin
            clear_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff     <= '0;
         in_row_ff     <= ROW_FIRST;
         out_col_ff    <= '0;
         out_row_ff    <= '0;
         clear_busy_ff <= 1'b1;
         clear_addr_ff <= '0;
      end else begin
         in_col_ff     <= in_col_in;
         in_row_ff     <= in_row_in;
         out_col_ff    <= out_col_in;
         out_row_ff    <= out_row_in;
         clear_busy_ff <= clear_busy_in;
         clear_addr_ff <= clear_addr_in;
      end
   end

   assign info.emit         = emit;
   assign info.col_zero     = (in_col_ff == '0);
   assign info.top_off      = (out_row_ff == '0);
   assign info.bottom_off   = last_row;
   assign info.left_off     = (out_col_ff == '0);
   assign info.right_off    = eor;
   assign info.end_of_row   = eor;
   assign info.end_of_frame = eof;

   assign rd_col     = in_col_ff;
   assign clear_busy = clear_busy_ff;
   assign clear_addr = clear_addr_ff;

endmodule

FILE: rtl/conv3x3_zero_pad_stream.sv
// top level of the streaming 3x3 convolution with zero padding
//
// Takes one 8-bit pixel per clock in raster order and returns one convolved
// pixel per clock when running and not stalled: the result for a pixel comes
// out with the transaction that carries its lower-right neighbour, W+1
// transactions later, and W+1 flush transactions drain the last row. Each
// transaction goes through three register stages (counters and line ram
// read, window and nine products, sum and saturation into the output
// register); the rate of one per cycle is held by the line ram's
// read-modify-write per column, with the write of one transaction forwarded
// to the read of the next when both hit the same column. After reset the
// line ram is cleared at all MAX_LINE_WIDTH addresses, while req_stream is
// not ready; register writes are taken at any time but belong between frames.
module conv3x3_zero_pad_stream import c3zp_pkg::*; #(
   parameter int MAX_LINE_WIDTH = MAX_LINE_WIDTH_DEF,
   parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   c3zp_req_if.sink              req_stream,
   c3zp_rsp_if.source            rsp_stream,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int COL_W  = $clog2(MAX_LINE_WIDTH);
   localparam int LINE_W = 2 * PIXEL_W;
   localparam int LAST   = KERNEL_SIZE - 1;

   cfg_type       cfg;
   item_info_type acc_info;
   logic [COL_W-1:0] rd_col, clear_addr;
   logic             clear_busy;

   logic accept, s1_go, s2_free, rsp_adv;

   // stage 1 registers
   logic                 s1_valid_ff, s1_valid_in;
   item_info_type        s1_info_ff;
   logic [PIXEL_W-1:0]   s1_pix_ff;
   logic [COL_W-1:0]     s1_col_ff;
   logic                 fwd_ff, fwd_in;
   logic [LINE_W-1:0]    fwd_data_ff;

   // line ram
   logic                 ram_wr_en;
   logic [COL_W-1:0]     ram_wr_addr;
   logic [LINE_W-1:0]    ram_wr_data, ram_rd_data, line_word;
   logic [PIXEL_W-1:0]   line_up, line_lo;

   // 3x3 window, [row][column], newest column on the right
   logic [KERNEL_SIZE-1:0][KERNEL_SIZE-1:0][PIXEL_W-1:0] win_ff, win_in;
   logic [KERNEL_SIZE-1:0][PIXEL_W-1:0]                  new_col;
   logic [KERNEL_SIZE-1:0][KERNEL_SIZE-1:0][PIXEL_W-1:0] taps;
   logic signed [PROD_W-1:0] prod_in [KERNEL_SIZE][KERNEL_SIZE];

   // stage 2 registers
   logic                     s2_valid_ff, s2_valid_in;
   logic signed [PROD_W-1:0] s2_prod_ff [KERNEL_SIZE][KERNEL_SIZE];
   logic                     s2_eor_ff, s2_eof_ff;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [PIXEL_W-1:0]   rsp_pixel_ff;
   logic                 rsp_eor_ff, rsp_eof_ff;

   logic signed [ACC_W-1:0] acc_sum;
   logic [ACC_W-1:0]        acc_mag, acc_shift;
   logic [PIXEL_W-1:0]      sat_pixel;

   c3zp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   c3zp_ctrl #(
      .MAX_LINE_WIDTH (MAX_LINE_WIDTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .accept     (accept),
      .info       (acc_info),
      .rd_col     (rd_col),
      .clear_busy (clear_busy),
      .clear_addr (clear_addr)
   );

   // handshake and stage advance
   assign rsp_adv  = !rsp_valid_ff || rsp_stream.ready;
   assign s2_free  = !s2_valid_ff || rsp_adv;
   assign s1_go    = s1_valid_ff && (!s1_info_ff.emit || s2_free);
   assign req_stream.ready = !clear_busy && (!s1_valid_ff || s1_go);
   assign accept   = req_stream.valid && req_stream.ready;

   // line ram word: upper line in the high byte, lower line in the low byte
   assign line_word = fwd_ff ? fwd_data_ff : ram_rd_data;
   assign line_up   = line_word[LINE_W-1:PIXEL_W];
   assign line_lo   = line_word[PIXEL_W-1:0];

   // clearing pass first, then write back of the shifted column
   always_comb begin
      if (clear_busy) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clear_addr;
         ram_wr_data = '0;
      end else begin
         ram_wr_en   = s1_go;
         ram_wr_addr = s1_col_ff;
         ram_wr_data = {line_lo, s1_pix_ff};
      end
   end

   c3zp_ram #(
      .WIDTH (LINE_W),
      .DEPTH (MAX_LINE_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (accept),
      .rd_addr (rd_col),
      .rd_data (ram_rd_data)
   );

   // forward the write back when the next read hits the same column
   assign fwd_in = s1_go && (s1_col_ff == rd_col);

   // stage 1 capture
   assign s1_valid_in = accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (accept) begin
            fwd_ff <= fwd_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_info_ff  <= acc_info;
         s1_pix_ff   <= req_stream.flush ? '0 : req_stream.pixel_in;
         s1_col_ff   <= rd_col;
         fwd_data_ff <= {line_lo, s1_pix_ff};
      end
   end

   // window shift and tap selection
   always_comb begin
      new_col[0] = line_up;
      new_col[1] = line_lo;
      new_col[2] = s1_pix_ff;
      for (int r = 0; r < KERNEL_SIZE; r++) begin
         win_in[r][0] = win_ff[r][1];
         win_in[r][1] = win_ff[r][2];
         win_in[r][2] = new_col[r];
         taps[r][0]   = win_ff[r][1];
         taps[r][1]   = win_ff[r][2];
         taps[r][2]   = s1_info_ff.col_zero ? '0 : new_col[r];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else if (s1_go) begin
         win_ff <= win_in;
      end
   end

   // nine products, taps outside the frame forced to zero
   always_comb begin
      logic signed [COEF_W-1:0]  coef;
      logic signed [PIXEL_W:0]   tap_s;
      logic                      masked;
      for (int r = 0; r < KERNEL_SIZE; r++) begin
         for (int c = 0; c < KERNEL_SIZE; c++) begin
            coef   = $signed(cfg.kernel_rows[r][c*COEF_W +: COEF_W]);
            tap_s  = $signed({1'b0, taps[r][c]});
            masked = ((r == 0) && s1_info_ff.top_off) ||
                     ((r == LAST) && s1_info_ff.bottom_off) ||
                     ((c == 0) && s1_info_ff.left_off) ||
                     ((c == LAST) && s1_info_ff.right_off);
            prod_in[r][c] = masked ? '0 : PROD_W'(coef * tap_s);
         end
      end
   end

   // stage 2 capture
   assign s2_valid_in = (s1_go && s1_info_ff.emit) ? 1'b1 :
                        (rsp_adv ? 1'b0 : s2_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && s1_info_ff.emit) begin
         s2_prod_ff <= prod_in;
         s2_eor_ff  <= s1_info_ff.end_of_row;
         s2_eof_ff  <= s1_info_ff.end_of_frame;
      end
   end

   // sum, scale toward zero and saturate to the pixel range
   always_comb begin
      acc_sum = '0;
      for (int r = 0; r < KERNEL_SIZE; r++) begin
         for (int c = 0; c < KERNEL_SIZE; c++) begin
            acc_sum = acc_sum + ACC_W'(s2_prod_ff[r][c]);
         end
      end
      acc_mag   = acc_sum;
      acc_shift = acc_mag >> COEF_FRAC_BITS;
      if (acc_sum <= 0) begin
         sat_pixel = '0;
      end else if (acc_shift > ACC_W'(PIXEL_MAX)) begin
         sat_pixel = PIXEL_MAX;
      end else begin
         sat_pixel = acc_shift[PIXEL_W-1:0];
      end
   end

   // output register
   assign rsp_valid_in = (s2_valid_ff && rsp_adv) ? 1'b1 :
                         (rsp_stream.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_valid_ff && rsp_adv) begin
         rsp_pixel_ff <= sat_pixel;
         rsp_eor_ff   <= s2_eor_ff;
         rsp_eof_ff   <= s2_eof_ff;
      end
   end

   assign rsp_stream.valid        = rsp_valid_ff;
   assign rsp_stream.pixel_out    = rsp_pixel_ff;
   assign rsp_stream.end_of_row   = rsp_eor_ff;
   assign rsp_stream.end_of_frame = rsp_eof_ff;

endmodule

FILE: rtl/c3zp_checker.sv
// port-level checks on the convolution stream, bound to the top level
module c3zp_checker import c3zp_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [PIXEL_W-1:0] pixel_out,
   input logic               end_of_row,
   input logic               end_of_frame
);

   // line ram clearing keeps the input closed right after reset
   assert property (@(posedge clock) reset |=> !req_ready)
      else $error("input ready right after reset");

   // a stalled result stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // and keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable({pixel_out, end_of_row, end_of_frame}))
      else $error("result payload changed while stalled");

   // the last pixel of a frame always closes a row
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && end_of_frame |-> end_of_row)
      else $error("end of frame without end of row");

endmodule

bind conv3x3_zero_pad_stream c3zp_checker u_c3zp_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_stream.ready),
   .rsp_valid    (rsp_stream.valid),
   .rsp_ready    (rsp_stream.ready),
   .pixel_out    (rsp_stream.pixel_out),
   .end_of_row   (rsp_stream.end_of_row),
   .end_of_frame (rsp_stream.end_of_frame)
);
